/* hw/rtl/file_header_validator_top_assert.svh */
// Assertion macros used by the header validator datapath (fhv_datapath).
// Needs a clock named clk and a synchronous active-high reset named rst in scope.
`ifndef FILE_HEADER_VALIDATOR_TOP_ASSERT_SVH
`define FILE_HEADER_VALIDATOR_TOP_ASSERT_SVH

// Condition in this cycle implies a consequence in the next cycle
`define FHV_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Condition in this cycle implies a consequence in the same cycle
`define FHV_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/fhv_pkg.sv */
// Shared constants, status codes and the result type of the header validator.
// No dependencies.
package fhv_pkg;

  // Page geometry
  localparam int PAGE_BYTES = 4096;
  localparam int POS_W      = $clog2(PAGE_BYTES);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(PAGE_BYTES - 1);

  // Header field offsets (each field is four bytes, little endian)
  localparam logic [POS_W-1:0] SIZE_AT  = POS_W'(8);
  localparam logic [POS_W-1:0] COUNT_AT = POS_W'(12);
  localparam logic [POS_W-1:0] SUM_AT   = POS_W'(16);
  localparam logic [POS_W-1:0] SUM_END  = POS_W'(20);
  localparam logic [POS_W-1:0] MAGIC_END = POS_W'(8);

  // Expected magic bytes 0..7
  localparam logic [7:0] MAGIC [8] = '{8'h50, 8'h46, 8'h44, 8'h42,
                                       8'h30, 8'h30, 8'h30, 8'h31};

  // FNV-1a 32 constants
  localparam logic [31:0] HASH_BASIS = 32'd2166136261;
  localparam logic [31:0] HASH_PRIME = 32'd16777619;

  // Length check widths
  localparam int LEN_W  = 48;
  localparam int NEED_W = 33 + $clog2(PAGE_BYTES + 1);
  localparam int CMP_W  = (NEED_W > LEN_W) ? NEED_W : LEN_W;

  // Status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_MAGIC = 3'd1;
  localparam logic [2:0] ST_BAD_SIZE  = 3'd2;
  localparam logic [2:0] ST_BAD_SUM   = 3'd3;
  localparam logic [2:0] ST_TRUNC     = 3'd4;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] page_count;
    logic [31:0] hash_value;
  } result_t;

endpackage

/* hw/rtl/file_header_validator_top.sv */
// Top level of the storage file header validator: input register, config
// register, datapath and result register. Depends on fhv_pkg, fhv_datapath, fhv_out_reg.

// Takes the header page one byte per item and gives one result after the
// last byte of each page of fhv_pkg::PAGE_BYTES bytes. It sustains one byte
// per clock cycle unless a page's last byte stalls on an untaken result; the
// rate is set by the FNV-1a hash update, one 32-bit constant multiply per
// byte between the input register and the hash register. A result waits in
// the result register while the next page streams in. Write file_length
// through the cfg channel (always ready) only between pages or while no byte
// is in flight; it takes effect for the next page check.
module file_header_validator_top
  import fhv_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  // Byte input
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       byte_value,
  // Result output
  output logic             out_valid,
  input  logic             out_stall,
  output logic [2:0]       status,
  output logic [31:0]      page_count,
  output logic [31:0]      hash_value,
  // File length register write
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [LEN_W-1:0] cfg_data
);

  logic             in_vld;
  logic             in_vld_next;
  logic [7:0]       in_byte;
  logic [LEN_W-1:0] file_length;
  logic             go;
  logic             last;
  result_t          result;

  // Process the held byte unless it ends a page and the result slot is blocked
  assign go       = in_vld && (!last || !out_valid || !out_stall);
  assign in_stall = in_vld && !go;
  assign cfg_ready = 1'b1;

  always_comb begin
    if (in_valid && !in_stall) begin
      in_vld_next = 1'b1;
    end else if (go) begin
      in_vld_next = 1'b0;
    end else begin
      in_vld_next = in_vld;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else begin
      in_vld <= in_vld_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte <= byte_value;
    end
  end

  // Config register
  always_ff @(posedge clk) begin
    if (rst) begin
      file_length <= '0;
    end else if (cfg_valid && cfg_ready) begin
      file_length <= cfg_data;
    end
  end

  fhv_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .go          (go),
    .in_byte     (in_byte),
    .file_length (file_length),
    .last        (last),
    .result      (result)
  );

  fhv_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .load       (go && last),
    .result     (result),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .page_count (page_count),
    .hash_value (hash_value)
  );

endmodule

/* hw/rtl/fhv_datapath.sv */
// Per-byte header datapath: position counter, magic check, field capture,
// FNV-1a hash and the final status. Depends on fhv_pkg and the assert macros.
`include "file_header_validator_top_assert.svh"

module fhv_datapath
  import fhv_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             go,
  input  logic [7:0]       in_byte,
  input  logic [LEN_W-1:0] file_length,
  output logic             last,
  output result_t          result
);

  logic [POS_W-1:0]  pos;
  logic [31:0]       hash;
  logic              magic_good;
  logic [31:0]       size_field;
  logic [31:0]       count_field;
  logic [31:0]       stored_sum;
  logic              short_len;

  logic [7:0]        hb;
  logic [31:0]       hash_next;
  logic [NEED_W-1:0] need;
  logic              in_magic;
  logic              in_size;
  logic              in_count;
  logic              in_sum;
  logic [4:0]        lane;

  // Decode which header region the current byte falls in
  assign in_magic = (pos < MAGIC_END);
  assign in_size  = !in_magic && (pos < COUNT_AT);
  assign in_count = (pos >= COUNT_AT) && (pos < SUM_AT);
  assign in_sum   = (pos >= SUM_AT) && (pos < SUM_END);
  assign lane     = {pos[1:0], 3'b000};
  assign last     = (pos == LAST_POS);

  // Hash the byte, with checksum bytes taken as zero
  assign hb        = in_sum ? 8'd0 : in_byte;
  assign hash_next = (hash ^ {24'd0, hb}) * HASH_PRIME;

  // Bytes needed for the header page plus all data pages
  assign need = NEED_W'({1'b0, count_field} + 33'd1) * NEED_W'(PAGE_BYTES);

  // Register the length check; count is stable long before the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      short_len <= 1'b0;
    end else begin
      short_len <= (CMP_W'(file_length) < CMP_W'(need));
    end
  end

  // Advance position and accumulate per item, rewind after the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= '0;
      hash        <= HASH_BASIS;
      magic_good  <= 1'b1;
      size_field  <= '0;
      count_field <= '0;
      stored_sum  <= '0;
    end else if (go) begin
      if (last) begin
        pos         <= '0;
        hash        <= HASH_BASIS;
        magic_good  <= 1'b1;
        size_field  <= '0;
        count_field <= '0;
        stored_sum  <= '0;
      end else begin
        pos  <= pos + POS_W'(1);
        hash <= hash_next;
        if (in_magic && (in_byte != MAGIC[pos[2:0]])) begin
          magic_good <= 1'b0;
        end
        if (in_size) begin
          size_field[lane +: 8] <= in_byte;
        end
        if (in_count) begin
          count_field[lane +: 8] <= in_byte;
        end
        if (in_sum) begin
          stored_sum[lane +: 8] <= in_byte;
        end
      end
    end
  end

  // Pick the first failing check for the final byte
  always_comb begin
    result.page_count = count_field;
    result.hash_value = hash_next;
    if (!magic_good) begin
      result.status = ST_BAD_MAGIC;
    end else if (size_field != 32'(PAGE_BYTES)) begin
      result.status = ST_BAD_SIZE;
    end else if (stored_sum != hash_next) begin
      result.status = ST_BAD_SUM;
    end else if (short_len) begin
      result.status = ST_TRUNC;
    end else begin
      result.status = ST_OK;
    end
  end

  `FHV_ASSERT_NEXT(a_rewind, go && last, (pos == '0) && (hash == HASH_BASIS),
    "position or hash did not rewind after the last byte")
  `FHV_ASSERT_NEXT(a_advance, go && !last, pos == $past(pos) + POS_W'(1),
    "position did not advance by one byte")
  `FHV_ASSERT_NEXT(a_hold, !go, $stable(pos) && $stable(hash),
    "position or hash moved without an item")

endmodule

/* hw/rtl/fhv_out_reg.sv */
// Result register of the header validator with valid/stall handshake.
// Depends on fhv_pkg.
module fhv_out_reg
  import fhv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  result_t     result,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [31:0] page_count,
  output logic [31:0] hash_value
);

  logic vld;
  logic vld_next;

  // Set on a new result, drop once the item is taken
  always_comb begin
    if (load) begin
      vld_next = 1'b1;
    end else if (!out_stall) begin
      vld_next = 1'b0;
    end else begin
      vld_next = vld;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else begin
      vld <= vld_next;
    end
  end

  // Capture the payload only when a result is loaded
  always_ff @(posedge clk) begin
    if (load) begin
      status     <= result.status;
      page_count <= result.page_count;
      hash_value <= result.hash_value;
    end
  end

  assign out_valid = vld;

endmodule
